// File: rtl/pfr_pkg.sv
// Shared types and constants for the page frame replacement block.
// Used by pfr_ctrl, pfr_dp and page_frame_replacement_core; no dependencies.
package pfr_pkg;

  // Default sizing of the frame table.
  localparam int FRAME_COUNT_DEF = 16;
  localparam int PAGE_COUNT_DEF  = 8;
  localparam int STAMP_WIDTH_DEF = 32;

  // Fixed field widths.
  localparam int COUNT_W     = 32;
  localparam int PAGE_REF_W  = 3;
  localparam int FRAMES_W    = 5;
  localparam int FRAME_IDX_W = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;

  // Reset value of the frames-in-use register.
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd16;

  // Victim selection policies.
  typedef enum logic [1:0] {
    POL_LRU  = 2'd0,
    POL_FIFO = 2'd1,
    POL_LFU  = 2'd2,
    POL_WIPE = 2'd3
  } policy_e;

  // Where the referenced page ended up.
  typedef enum logic [1:0] {
    PLACE_HIT    = 2'd0,
    PLACE_FREE   = 2'd1,
    PLACE_VICTIM = 2'd2
  } placement_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic issue;
    logic update;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_issue;
    logic pipe_busy;
    logic out_free;
  } status_t;

endpackage

// File: rtl/pfr_ctrl.sv
// Sequencing controller of the page frame replacement block.
// Depends on pfr_pkg for the command and status structs.
module pfr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  pfr_pkg::status_t status_i,
  output pfr_pkg::cmd_t    cmd_o
);
  import pfr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPD
  } state_e;

  state_e state_q;
  logic   ready_q;

  assign s_tready_o = ready_q;

  // Commands decoded from the current state and the status inputs.
  always_comb begin
    cmd_o.accept = s_tvalid_i && ready_q;
    cmd_o.issue  = (state_q == ST_SCAN);
    cmd_o.update = (state_q == ST_UPD) && status_i.out_free;
  end

  // State register and registered request-ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (s_tvalid_i && ready_q) begin
            state_q <= ST_SCAN;
            ready_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (status_i.last_issue) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!status_i.pipe_busy) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: rtl/pfr_dp.sv
// Datapath of the page frame replacement block: frame memories, scan
// pipeline, victim trackers, counters and the result register. Uses pfr_pkg.
module pfr_dp #(
  parameter int FRAME_COUNT = pfr_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_COUNT  = pfr_pkg::PAGE_COUNT_DEF,
  parameter int STAMP_WIDTH = pfr_pkg::STAMP_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic [pfr_pkg::PAGE_REF_W-1:0]      page_ref_i,
  input  pfr_pkg::cmd_t                       cmd_i,
  output pfr_pkg::status_t                    status_o,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic                                was_hit_o,
  output logic [1:0]                          placement_o,
  output logic [pfr_pkg::FRAME_IDX_W-1:0]     frame_index_o,
  output logic [pfr_pkg::COUNT_W-1:0]         fault_total_o
);
  import pfr_pkg::*;

  localparam int IW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int NW = $clog2(FRAME_COUNT + 1);
  localparam int PW = $clog2(PAGE_COUNT);
  localparam int MW = (STAMP_WIDTH > COUNT_W) ? STAMP_WIDTH : COUNT_W;

  // Configuration registers.
  policy_e             policy_q;
  logic [FRAMES_W-1:0] frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_LRU;
      frames_q <= FRAMES_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POLICY_MODE:   policy_q <= policy_e'(cfg_wdata_i[1:0]);
        CFG_FRAMES_IN_USE: frames_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the number of frames taking part to one through FRAME_COUNT.
  logic [NW-1:0] n_act;
  always_comb begin
    if (frames_q == '0) begin
      n_act = NW'(1);
    end else if (32'(frames_q) > 32'(FRAME_COUNT)) begin
      n_act = NW'(FRAME_COUNT);
    end else begin
      n_act = NW'(frames_q);
    end
  end

  // Reduce the page number into the page range by repeated subtraction.
  // A three-bit page needs at most three steps, as the page count is at least two.
  logic [8:0]    pm;
  logic [PW-1:0] page_mod;
  always_comb begin
    pm = 9'(page_ref_i);
    for (int k = 0; k < 3; k++) begin
      if (pm >= 9'(PAGE_COUNT)) begin
        pm = pm - 9'(PAGE_COUNT);
      end
    end
    page_mod = pm[PW-1:0];
  end

  // Storage: frame memories, valid bits and per-page use counts.
  logic [PW-1:0]          page_mem  [FRAME_COUNT];
  logic [STAMP_WIDTH-1:0] last_mem  [FRAME_COUNT];
  logic [STAMP_WIDTH-1:0] load_mem  [FRAME_COUNT];
  logic [COUNT_W-1:0]     count_mem [PAGE_COUNT];
  logic [FRAME_COUNT-1:0] frame_valid_q;
  logic [PAGE_COUNT-1:0]  pg_vld_q;

  // Request registers.
  logic [PW-1:0] page_q;
  logic [NW-1:0] n_q;
  logic [IW-1:0] idx_q;

  // Scan pipeline registers.
  logic                   v1_q, v2_q;
  logic [PW-1:0]          p1_page_q, p2_page_q;
  logic [STAMP_WIDTH-1:0] p1_last_q, p2_last_q;
  logic [STAMP_WIDTH-1:0] p1_load_q, p2_load_q;
  logic [IW-1:0]          p1_idx_q, p2_idx_q;
  logic                   p1_fv_q, p2_fv_q;
  logic [COUNT_W-1:0]     p2_cnt_q, self_cnt_q;
  logic                   p2_cv_q, self_cv_q;

  // Search trackers.
  logic          hit_found_q, free_found_q, first_q;
  logic [IW-1:0] hit_idx_q, free_idx_q, best_idx_q;
  logic [MW-1:0] best_metric_q;

  // Counters and the result register.
  logic [STAMP_WIDTH-1:0] stamp_q;
  logic [COUNT_W-1:0]     fault_q;
  logic                   m_valid_q;
  logic                   was_hit_q;
  logic [1:0]             placement_q;
  logic [FRAME_IDX_W-1:0] frame_idx_q;
  logic [COUNT_W-1:0]     fault_out_q;

  // Status back to the controller.
  logic [NW-1:0] n_m1;
  assign n_m1 = n_q - NW'(1);
  always_comb begin
    status_o.last_issue = (idx_q == n_m1[IW-1:0]);
    status_o.pipe_busy  = v1_q || v2_q;
    status_o.out_free   = !m_valid_q || m_tready_i;
  end

  // Frame memory reads, one frame per cycle, and the count reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      p1_page_q <= page_mem[idx_q];
      p1_last_q <= last_mem[idx_q];
      p1_load_q <= load_mem[idx_q];
      p1_idx_q  <= idx_q;
      p1_fv_q   <= frame_valid_q[idx_q];
    end
    p2_page_q  <= p1_page_q;
    p2_last_q  <= p1_last_q;
    p2_load_q  <= p1_load_q;
    p2_idx_q   <= p1_idx_q;
    p2_fv_q    <= p1_fv_q;
    p2_cnt_q   <= count_mem[p1_page_q];
    p2_cv_q    <= pg_vld_q[p1_page_q];
    self_cnt_q <= count_mem[page_q];
    self_cv_q  <= pg_vld_q[page_q];
    if (cmd_i.accept) begin
      page_q <= page_mod;
      n_q    <= n_act;
    end
  end

  // Metric of the frame at the end of the pipeline under the current policy.
  logic [MW-1:0] metric;
  always_comb begin
    unique case (policy_q)
      POL_LRU:  metric = MW'(p2_last_q);
      POL_FIFO: metric = MW'(p2_load_q);
      default:  metric = p2_cv_q ? MW'(p2_cnt_q) : '0;
    endcase
  end

  // Update values: saturating counters and the chosen frame.
  logic [STAMP_WIDTH-1:0] stamp_nx;
  logic [COUNT_W-1:0]     self_cnt, cnt_nx, fault_nx;
  logic [IW-1:0]          slot;
  logic                   victim;
  placement_e             place;
  logic [IW+3:0]          slot_ext;
  always_comb begin
    stamp_nx = (stamp_q == '1) ? stamp_q : stamp_q + 1'b1;
    self_cnt = self_cv_q ? self_cnt_q : '0;
    cnt_nx   = (self_cnt == '1) ? self_cnt : self_cnt + 1'b1;
    fault_nx = (fault_q == '1) ? fault_q : fault_q + 1'b1;
    victim   = 1'b0;
    if (hit_found_q) begin
      slot  = hit_idx_q;
      place = PLACE_HIT;
    end else if (free_found_q) begin
      slot  = free_idx_q;
      place = PLACE_FREE;
    end else begin
      victim = 1'b1;
      slot   = (policy_q == POL_WIPE) ? '0 : best_idx_q;
      place  = PLACE_VICTIM;
    end
    slot_ext = {4'b0000, slot};
  end

  // Control registers: scan index, pipeline valids, trackers, counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q         <= '0;
      v1_q          <= 1'b0;
      v2_q          <= 1'b0;
      hit_found_q   <= 1'b0;
      free_found_q  <= 1'b0;
      first_q       <= 1'b1;
      hit_idx_q     <= '0;
      free_idx_q    <= '0;
      best_idx_q    <= '0;
      best_metric_q <= '0;
      stamp_q       <= '0;
      fault_q       <= '0;
      frame_valid_q <= '0;
      pg_vld_q      <= '0;
      m_valid_q     <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.accept) begin
        idx_q        <= '0;
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
        first_q      <= 1'b1;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + 1'b1;
      end
      // Track first hit, first free frame and smallest metric.
      if (v2_q) begin
        if (p2_fv_q && (p2_page_q == page_q) && !hit_found_q) begin
          hit_found_q <= 1'b1;
          hit_idx_q   <= p2_idx_q;
        end
        if (!p2_fv_q && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= p2_idx_q;
        end
        if (first_q || (metric < best_metric_q)) begin
          best_idx_q    <= p2_idx_q;
          best_metric_q <= metric;
        end
        first_q <= 1'b0;
      end
      // Commit the reference.
      if (cmd_i.update) begin
        stamp_q          <= stamp_nx;
        pg_vld_q[page_q] <= 1'b1;
        if (!hit_found_q) begin
          fault_q <= fault_nx;
          if (victim && (policy_q == POL_WIPE)) begin
            for (int i = 1; i < FRAME_COUNT; i++) begin
              if (NW'(i) < n_q) begin
                frame_valid_q[i] <= 1'b0;
              end
            end
          end
          frame_valid_q[slot] <= 1'b1;
        end
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Memory writes and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      last_mem[slot]    <= stamp_nx;
      count_mem[page_q] <= cnt_nx;
      if (!hit_found_q) begin
        page_mem[slot] <= page_q;
        load_mem[slot] <= stamp_nx;
      end
      was_hit_q   <= hit_found_q;
      placement_q <= place;
      frame_idx_q <= slot_ext[FRAME_IDX_W-1:0];
      fault_out_q <= hit_found_q ? fault_q : fault_nx;
    end
  end

  assign m_tvalid_o    = m_valid_q;
  assign was_hit_o     = was_hit_q;
  assign placement_o   = placement_q;
  assign frame_index_o = frame_idx_q;
  assign fault_total_o = fault_out_q;

`ifndef SYNTHESIS
  // A miss below saturation adds exactly one fault.
  a_fault_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && !hit_found_q && (fault_q != '1)
    |=> fault_q == $past(fault_q) + 1'b1)
    else $error("fault count did not advance on a miss");

  // Every commit produces a result.
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> m_valid_q)
    else $error("commit without a result");

  // A hit always names a valid frame.
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update && hit_found_q |-> frame_valid_q[hit_idx_q])
    else $error("hit on a free frame");

  // The access stamp never goes backward.
  a_stamp_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> stamp_q >= $past(stamp_q))
    else $error("access stamp decreased");
`endif

endmodule

// File: rtl/page_frame_replacement_core.sv
// A request is taken, then the controller scans the n frames taking part, where n
// is the number of frames taking part, reading one frame per cycle from the frame
// memories; it then drains the scan pipeline and commits the reference into the
// result register once that register is free. A new request is not accepted
// until the reference is committed. Reset is asynchronous and active low; it
// clears the valid bits and counters at once.
module page_frame_replacement_core #(
  parameter int FRAME_COUNT = pfr_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_COUNT  = pfr_pkg::PAGE_COUNT_DEF,
  parameter int STAMP_WIDTH = pfr_pkg::STAMP_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: page_ref[2:0], zero fill.
  input  logic [pfr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0: was_hit[0], placement[2:1], frame_index[6:3],
  // fault_total[38:7], zero fill.
  output logic [pfr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import pfr_pkg::*;

  cmd_t                   cmd;
  status_t                status;
  logic                   was_hit;
  logic [1:0]             placement;
  logic [FRAME_IDX_W-1:0] frame_index;
  logic [COUNT_W-1:0]     fault_total;

  // Sequencer.
  pfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Frame table and counters.
  pfr_dp #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_COUNT  (PAGE_COUNT),
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .page_ref_i    (s_axis_tdata[PAGE_REF_W-1:0]),
    .cmd_i         (cmd),
    .status_o      (status),
    .m_tready_i    (m_axis_tready),
    .m_tvalid_o    (m_axis_tvalid),
    .was_hit_o     (was_hit),
    .placement_o   (placement),
    .frame_index_o (frame_index),
    .fault_total_o (fault_total)
  );

  // Pack the result fields.
  assign m_axis_tdata = {1'b0, fault_total, frame_index, placement, was_hit};

endmodule

// File: tb/page_table_checker.sv
`timescale 1ns / 1ps
// Checker for the page frame replacement core: watches the register port and both streams,
// keeps its own copy of the frame table and compares every result. Depends on pfr_pkg.
module page_table_checker
  import pfr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  input  logic [IN_TDATA_W-1:0]  req_data_i,
  input  logic                   rsp_valid_i,
  input  logic                   rsp_ready_i,
  input  logic [OUT_TDATA_W-1:0] rsp_data_i,
  output int                     results_seen_o,
  output int                     errors_o
);

  localparam int FRAMES = FRAME_COUNT_DEF;
  localparam int PAGES  = PAGE_COUNT_DEF;
  localparam logic [COUNT_W-1:0] SAT = '1;

  typedef struct packed {
    logic                   was_hit;
    placement_e             placement;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [COUNT_W-1:0]     fault_total;
  } outcome_t;

  // Mirror of the frame table and its registers.
  policy_e                 policy;
  logic [FRAMES_W-1:0]     frames_cfg;
  logic [FRAMES-1:0]       frame_valid;
  logic [PAGE_REF_W-1:0]   frame_page   [FRAMES];
  logic [STAMP_WIDTH_DEF-1:0] last_use  [FRAMES];
  logic [STAMP_WIDTH_DEF-1:0] loaded_at [FRAMES];
  logic [COUNT_W-1:0]      use_count    [PAGES];
  logic [STAMP_WIDTH_DEF-1:0] access_stamp;
  logic [COUNT_W-1:0]      fault_count;

  outcome_t pending_outcomes[$];
  int       mismatches;

  // Works out the outcome of one page reference and updates the mirror.
  function automatic outcome_t service_reference(input logic [PAGE_REF_W-1:0] page);
    outcome_t res;
    int       n;
    int       slot;
    logic     hit;
    logic     free;
    logic     less;

    n = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
    hit  = 1'b0;
    free = 1'b0;
    slot = 0;
    for (int i = 0; i < n; i++) begin
      if (!hit && frame_valid[i] && frame_page[i] == page) begin
        hit  = 1'b1;
        slot = i;
      end
    end

    if (!hit) begin
      for (int i = 0; i < n; i++) begin
        if (!free && !frame_valid[i]) begin
          free = 1'b1;
          slot = i;
        end
      end
      if (!free) begin
        // No free frame: pick a victim, lowest index wins ties.
        slot = 0;
        if (policy == POL_WIPE) begin
          for (int i = 1; i < n; i++) begin
            frame_valid[i] = 1'b0;
            frame_page[i]  = '0;
          end
        end else begin
          for (int i = 1; i < n; i++) begin
            case (policy)
              POL_LRU:  less = last_use[i] < last_use[slot];
              POL_FIFO: less = loaded_at[i] < loaded_at[slot];
              default:  less = use_count[frame_page[i]] < use_count[frame_page[slot]];
            endcase
            if (less) slot = i;
          end
        end
      end
    end

    // Stamp and use count saturate.
    if (access_stamp != '1) access_stamp = access_stamp + 1'b1;
    if (use_count[page] != SAT) use_count[page] = use_count[page] + 1'b1;
    last_use[slot] = access_stamp;
    if (!hit) begin
      if (fault_count != SAT) fault_count = fault_count + 1'b1;
      frame_valid[slot] = 1'b1;
      frame_page[slot]  = page;
      loaded_at[slot]   = access_stamp;
    end

    res.was_hit     = hit;
    res.placement   = hit ? PLACE_HIT : (free ? PLACE_FREE : PLACE_VICTIM);
    res.frame_index = slot[FRAME_IDX_W-1:0];
    res.fault_total = fault_count;
    return res;
  endfunction

  task automatic report(input string field, input logic [COUNT_W-1:0] exp_v,
                        input logic [COUNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_o;
    if (!rst_ni) begin
      policy       = POL_LRU;
      frames_cfg   = FRAMES_RESET;
      frame_valid  = '0;
      access_stamp = '0;
      fault_count  = '0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i] = '0;
        last_use[i]   = '0;
        loaded_at[i]  = '0;
      end
      for (int p = 0; p < PAGES; p++) use_count[p] = '0;
      pending_outcomes.delete();
      mismatches = 0;
      results_seen_o <= 0;
      errors_o       <= 0;
    end else begin
      // Results first: a result leaving now belongs to an earlier request.
      if (rsp_valid_i && rsp_ready_i) begin
        results_seen_o <= results_seen_o + 1;
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with no request waiting, actual data %h", $time, rsp_data_i);
          mismatches++;
        end else begin
          exp_o = pending_outcomes.pop_front();
          report("was_hit", COUNT_W'(exp_o.was_hit), COUNT_W'(rsp_data_i[0]));
          report("placement", COUNT_W'(exp_o.placement), COUNT_W'(rsp_data_i[2:1]));
          report("frame_index", COUNT_W'(exp_o.frame_index), COUNT_W'(rsp_data_i[6:3]));
          report("fault_total", exp_o.fault_total, rsp_data_i[38:7]);
        end
      end
      // Register writes; indexes past the list are ignored.
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POLICY_MODE:   policy = policy_e'(cfg_wdata_i[1:0]);
          CFG_FRAMES_IN_USE: frames_cfg = cfg_wdata_i;
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) begin
        pending_outcomes.push_back(service_reference(req_data_i[PAGE_REF_W-1:0]));
      end
      errors_o <= mismatches;
    end
  end

endmodule

// File: tb/tb_page_frame_replacement_core.sv
`timescale 1ns / 1ps
// Top of the page frame replacement core testbench: clock, reset, request and register
// stimulus, result back-pressure and the verdict. Depends on pfr_pkg and page_table_checker.
module tb_page_frame_replacement_core;
  import pfr_pkg::*;

  localparam int IDLE_PCT     = 26;
  localparam int LONG_HOLD    = 400;
  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 86;
  localparam int TAIL_CYCLES  = 25;
  // Register indexes past the end of the register list.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int   requests_sent;
  int   results_seen;
  int   errors;
  logic steady;
  logic rx_hold;

  page_frame_replacement_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  page_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_data_i    (m_axis_tdata),
    .results_seen_o(results_seen),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random back-pressure, one long hold-off when asked.
  initial begin : result_sink
    logic held;
    held = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offers one page reference, with random idle cycles ahead of it.
  task automatic offer_page(input logic [PAGE_REF_W-1:0] page);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tdata  <= {{(IN_TDATA_W - PAGE_REF_W){1'b0}}, page};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stops offering and waits until every request has its result.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (results_seen != requests_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_table(input policy_e pol, input logic [FRAMES_W-1:0] frames);
    write_reg(CFG_POLICY_MODE, CFG_DATA_W'(pol));
    write_reg(CFG_FRAMES_IN_USE, frames);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [PAGE_REF_W-1:0] ws_base;
    logic [FRAMES_W-1:0]   frames;
    logic [PAGE_REF_W-1:0] page;

    requests_sent = 0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_POLICY_MODE;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    steady        <= 1'b0;
    rx_hold       <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill eight of the sixteen frames from empty, then two hits.
    for (int p = 0; p < 8; p++) offer_page(PAGE_REF_W'(p));
    offer_page(3'd7);
    offer_page(3'd0);
    settle();

    // Three frames with least recently used; frames above stay resident but inactive.
    set_table(POL_LRU, 5'd3);
    offer_page(3'd5);
    offer_page(3'd1);
    offer_page(3'd2);
    settle();
    set_table(POL_FIFO, 5'd3);
    offer_page(3'd3);
    offer_page(3'd4);
    settle();
    set_table(POL_LFU, 5'd3);
    offer_page(3'd6);
    offer_page(3'd5);
    settle();

    // Wipe, written with every data bit set; only the low two bits count.
    write_reg(CFG_POLICY_MODE, 5'b11111);
    cfg_we_i <= 1'b0;
    offer_page(3'd7);
    offer_page(3'd0);
    settle();

    // A frame count of zero acts as one frame.
    set_table(POL_LRU, 5'd0);
    offer_page(3'd6);
    offer_page(3'd6);
    settle();

    // Counts above the table depth act as the full table; spare indexes are ignored.
    write_reg(CFG_FRAMES_IN_USE, 5'd31);
    write_reg(CFG_SPARE_LO, 5'd31);
    write_reg(CFG_SPARE_HI, 5'd0);
    cfg_we_i <= 1'b0;
    offer_page(3'd7);
    offer_page(3'd3);
    settle();

    // Random phases: small frame counts dominate so that victims are chosen often.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case ($urandom_range(9))
        0:       frames = 5'd0;
        1:       frames = 5'd1;
        7:       frames = 5'd16;
        8:       frames = FRAMES_W'($urandom_range(31, 17));
        9:       frames = FRAMES_W'($urandom_range(15, 8));
        default: frames = FRAMES_W'($urandom_range(7, 2));
      endcase
      write_reg(CFG_POLICY_MODE, CFG_DATA_W'($urandom_range(3)));
      write_reg(CFG_FRAMES_IN_USE, frames);
      if ($urandom_range(3) == 0) begin
        write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                  CFG_DATA_W'($urandom_range(31)));
      end
      cfg_we_i <= 1'b0;
      rx_hold <= (ph == 2);
      steady  <= (ph == 4);
      ws_base = PAGE_REF_W'($urandom_range(7));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Mostly a small working set that drifts, with some scattered references.
        if ($urandom_range(99) < 75) page = ws_base + PAGE_REF_W'($urandom_range(2));
        else page = PAGE_REF_W'($urandom_range(7));
        if ($urandom_range(29) == 0) ws_base = ws_base + 1'b1;
        offer_page(page);
      end
      settle();
      steady <= 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && results_seen == requests_sent) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pfr_pkg.sv
rtl/pfr_ctrl.sv
rtl/pfr_dp.sv
rtl/page_frame_replacement_core.sv
tb/page_table_checker.sv
tb/tb_page_frame_replacement_core.sv
